### hw/rtl/eoc_pkg.sv
package eoc_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int STEP_W      = 16;
    localparam int POWER_W     = 12;
    localparam int TOTAL_W     = 16;
    localparam int PHASE_W     = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_STEP_ANGLE  = 2'd0;
    localparam cfg_index_t CFG_CALIB_POWER = 2'd1;
    localparam cfg_index_t CFG_TOTAL_STEPS = 2'd2;

    localparam logic [STEP_W-1:0]  STEP_ANGLE_RST  = 16'd256;
    localparam logic [POWER_W-1:0] CALIB_POWER_RST = 12'd400;
    localparam logic [TOTAL_W-1:0] TOTAL_STEPS_RST = 16'd4096;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FIND  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_GOTO  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SWEEP = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

    localparam int ZERO_WINDOW = 10;

endpackage

### hw/rtl/eoc_in_if.sv
interface eoc_in_if #(
    parameter int SAMPLE_BITS = eoc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] encoder_sample;

    modport source (output valid, output cmd, output encoder_sample, input ready);
    modport sink   (input valid, input cmd, input encoder_sample, output ready);
endinterface

### hw/rtl/eoc_out_if.sv
interface eoc_out_if #(
    parameter int ANGLE_BITS  = eoc_pkg::ANGLE_BITS_DEF,
    parameter int SAMPLE_BITS = eoc_pkg::SAMPLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [ANGLE_BITS-1:0]            drive_angle;
    logic [eoc_pkg::POWER_W-1:0]      drive_power;
    logic signed [SAMPLE_BITS-1:0]    offset_value;
    logic [eoc_pkg::PHASE_W-1:0]      phase;

    modport source (output valid, output drive_angle, output drive_power,
                    output offset_value, output phase, input ready);
    modport sink   (input valid, input drive_angle, input drive_power,
                    input offset_value, input phase, output ready);
endinterface

### hw/rtl/encoder_offset_calibration.sv
// a request's result is loaded in the OUT state after the EXEC state; a sweep request
//   that ends the sweep goes from EXEC to DIV and waits there for the serial divider
// a new request is taken only in the idle state, once the previous result is loaded
// a result held by a stalled receiver holds off the next request
// the divider retires one quotient bit per cycle over the whole exact sum
// reset: phase idle, run state cleared, registers at step 256, power 400, 4096 steps
module encoder_offset_calibration #(
    parameter int ANGLE_BITS  = eoc_pkg::ANGLE_BITS_DEF,
    parameter int SAMPLE_BITS = eoc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = eoc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  eoc_pkg::cfg_index_t             cfg_index,
    input  logic [eoc_pkg::CFG_DATA_W-1:0]  cfg_data,
    eoc_in_if.sink                          cmd_ch,
    eoc_out_if.source                       result_ch
);
    import eoc_pkg::*;

    localparam int AW   = ((ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W) + 1;
    localparam int MW   = ANGLE_BITS + STEP_W;
    localparam int SUMW = SAMPLE_BITS + COUNT_BITS;
    localparam int NW   = COUNT_BITS + 1;
    localparam int CW   = (NW > TOTAL_W) ? NW : TOTAL_W;
    localparam logic [AW-1:0] TURN = AW'(1) << ANGLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [STEP_W-1:0]         step_reg;
    logic [POWER_W-1:0]        calib_reg;
    logic [TOTAL_W-1:0]        total_reg;

    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [ANGLE_BITS-1:0]     angle_reg, angle_next;
    logic [COUNT_BITS-1:0]     index_reg, index_next;
    logic signed [SUMW-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]    offset_reg, offset_next;
    logic [POWER_W-1:0]        power_reg, power_next;

    logic                      cmd_reg;
    logic [SAMPLE_BITS-1:0]    sample_reg;
    logic [ANGLE_BITS-1:0]     prod_reg;
    logic                      neg_reg, neg_next;

    logic                      out_valid_reg;
    logic [ANGLE_BITS-1:0]     out_angle_reg;
    logic [POWER_W-1:0]        out_power_reg;
    logic [SAMPLE_BITS-1:0]    out_offset_reg;
    logic [PHASE_W-1:0]        out_phase_reg;

    logic                      accept;
    logic                      load_out;
    logic [MW-1:0]             prod_full;
    logic signed [SUMW-1:0]    sample_ext;
    logic signed [SUMW-1:0]    sum_add;
    logic [SUMW-1:0]           sum_mag;
    logic [AW-1:0]             angle_inc;
    logic [AW-1:0]             angle_dec;
    logic [NW-1:0]             count_next;
    logic                      sweep_end;
    logic                      in_window;
    logic                      sample_pos;
    logic [POWER_W-1:0]        half_power;
    logic                      div_start;
    logic                      div_done;
    logic [SUMW-1:0]           div_quo;
    logic [SAMPLE_BITS-1:0]    quo_trunc;

    assign accept   = cmd_ch.valid && (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || result_ch.ready);
    assign cmd_ch.ready = (state_reg == ST_IDLE);

    assign prod_full = MW'(index_reg) * MW'(step_reg);

    always_comb
    begin
        sample_ext = {{COUNT_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        sum_add    = sum_reg + sample_ext;
        sum_mag    = sum_add[SUMW-1] ? SUMW'(-sum_add) : SUMW'(sum_add);
        angle_inc  = AW'(angle_reg) + AW'(step_reg);
        angle_dec  = AW'(angle_reg) - AW'(step_reg);
        count_next = NW'(index_reg) + NW'(1);
        sweep_end  = (CW'(count_next) >= CW'(total_reg)) || count_next[COUNT_BITS];
        in_window  = !sample_reg[SAMPLE_BITS-1]
                     && (sample_reg < SAMPLE_BITS'(ZERO_WINDOW));
        sample_pos = !sample_reg[SAMPLE_BITS-1] && (|sample_reg);
        half_power = {1'b0, calib_reg[POWER_W-1:1]};
        quo_trunc  = div_quo[SAMPLE_BITS-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        angle_next  = angle_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        offset_next = offset_reg;
        power_next  = power_reg;
        neg_next    = neg_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
                if (cmd_reg)
                begin
                    phase_next  = PH_FIND;
                    angle_next  = '0;
                    index_next  = '0;
                    sum_next    = '0;
                    offset_next = '0;
                    power_next  = '0;
                end
                else
                begin
                    case (phase_reg)
                        PH_FIND:
                        begin
                            if (in_window)
                            begin
                                phase_next = PH_GOTO;
                            end
                            else if (sample_pos)
                            begin
                                angle_next = angle_dec[ANGLE_BITS-1:0];
                            end
                            else
                            begin
                                angle_next = angle_inc[ANGLE_BITS-1:0];
                            end
                            power_next = half_power;
                        end
                        PH_GOTO:
                        begin
                            if (angle_inc >= TURN)
                            begin
                                angle_next = '0;
                                phase_next = PH_SWEEP;
                            end
                            else
                            begin
                                angle_next = angle_inc[ANGLE_BITS-1:0];
                            end
                            power_next = half_power;
                        end
                        PH_SWEEP:
                        begin
                            angle_next = prod_reg;
                            power_next = calib_reg;
                            sum_next   = sum_add;
                            index_next = count_next[COUNT_BITS-1:0];
                            if (sweep_end)
                            begin
                                power_next = '0;
                                phase_next = PH_DONE;
                                neg_next   = sum_add[SUMW-1];
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            power_next = '0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    offset_next = neg_reg ? SAMPLE_BITS'(-quo_trunc) : quo_trunc;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    eoc_div #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_ANGLE_RST;
            calib_reg     <= CALIB_POWER_RST;
            total_reg     <= TOTAL_STEPS_RST;
            phase_reg     <= PH_IDLE;
            angle_reg     <= '0;
            index_reg     <= '0;
            sum_reg       <= '0;
            offset_reg    <= '0;
            power_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            angle_reg  <= angle_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
            power_reg  <= power_next;
            neg_reg    <= neg_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_ANGLE:  step_reg  <= cfg_data[STEP_W-1:0];
                    CFG_CALIB_POWER: calib_reg <= cfg_data[POWER_W-1:0];
                    CFG_TOTAL_STEPS: total_reg <= cfg_data[TOTAL_W-1:0];
                    default:         ;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_ch.cmd;
            sample_reg <= cmd_ch.encoder_sample;
            prod_reg   <= prod_full[ANGLE_BITS-1:0];
        end
        if (load_out)
        begin
            out_angle_reg  <= angle_reg;
            out_power_reg  <= power_reg;
            out_offset_reg <= offset_reg;
            out_phase_reg  <= phase_reg;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.drive_angle  = out_angle_reg;
    assign result_ch.drive_power  = out_power_reg;
    assign result_ch.offset_value = out_offset_reg;
    assign result_ch.phase        = out_phase_reg;

endmodule

### hw/rtl/eoc_div.sv
module eoc_div #(
    parameter int DIVIDEND_W = eoc_pkg::SAMPLE_BITS_DEF + eoc_pkg::COUNT_BITS_DEF,
    parameter int DIVISOR_W  = eoc_pkg::COUNT_BITS_DEF + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam int REM_W = DIVISOR_W + 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [REM_W-1:0] shifted;
    logic [REM_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted = {rem_reg[REM_W-2:0], quo_reg[DIVIDEND_W-1]};
        trial   = {1'b0, shifted} - {2'b00, div_reg};
        fits    = !trial[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (count_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[REM_W-1:0] : shifted;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
